// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the block transposition cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define BTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/btc_pkg.sv
// Types and constants of the block transposition cipher.
package btc_pkg;

  localparam int unsigned LenW  = 5;
  localparam int unsigned KeyW  = 4;
  localparam int unsigned DataW = 8;

  localparam logic [DataW-1:0] PadChar = 8'h20;

  localparam logic [LenW-1:0] BlockLengthReset = 5'd16;
  localparam logic [63:0]     KeyTableReset    = 64'hFEDC_BA98_7654_3210;

  localparam logic RegBlockLength = 1'b0;
  localparam logic RegKeyTable    = 1'b1;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] cipher_byte;
    logic             last_of_block;
    logic             last_of_message;
    logic             key_fault;
  } out_item_t;

endpackage

// File: rtl/btc_ifs.sv
// Valid/ready channel interfaces for plaintext and ciphertext transactions.
interface btc_in_if;
  import btc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface btc_out_if;
  import btc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/block_transposition_cipher.sv
// Top level of the block transposition cipher with its APB register port.
// A byte that does not close a block is taken while the cipher is idle.
// A closed block is emitted one ciphertext byte at a time, each read from the buffer
// and then held until the output takes it; input is held off while a block is emitted.
// Reset restores the block length and identity key and empties the current block.
`include "assert_macros.svh"

module block_transposition_cipher #(
  parameter int unsigned MAX_BLOCK = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  btc_in_if.sink           in_i,
  btc_out_if.source        out_o
);
  import btc_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_BLOCK);
  localparam int unsigned CntW  = $clog2(MAX_BLOCK + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [LenW-1:0]  len_reg_q;
  logic [63:0]      key_q;
  logic [CntW-1:0]  eff_len;
  logic             cfg_wr;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d, fill_inc;
  logic [CntW-1:0]  done_q, done_d;
  logic             eom_q, eom_d;
  logic [AddrW-1:0] j_q, j_d;
  logic             in_acc, complete;

  logic [DataW-1:0] mem [MAX_BLOCK];
  logic [DataW-1:0] rdata_q;
  logic [KeyW-1:0]  src;
  logic             src_fault, src_pad, src_last;
  logic             space_q, fault_q, lob_q, lom_q;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_reg_q <= BlockLengthReset;
      key_q     <= KeyTableReset;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        RegBlockLength: len_reg_q <= pwdata[LenW-1:0];
        RegKeyTable:    key_q     <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      RegBlockLength: prdata = {{(64 - LenW){1'b0}}, len_reg_q};
      RegKeyTable:    prdata = key_q;
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    if (len_reg_q == '0) begin
      eff_len = CntW'(1);
    end else if (len_reg_q > LenW'(MAX_BLOCK)) begin
      eff_len = CntW'(MAX_BLOCK);
    end else begin
      eff_len = CntW'(len_reg_q);
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign fill_inc   = fill_q + CntW'(1);
  assign complete   = (fill_inc >= eff_len) | in_i.payload.end_of_message;

  assign src       = KeyW'(key_q >> (6'(j_q) << 2));
  assign src_fault = LenW'(src) >= LenW'(eff_len);
  assign src_pad   = LenW'(src) >= LenW'(done_q);
  assign src_last  = (LenW'(j_q) + LenW'(1)) == LenW'(eff_len);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    done_d  = done_q;
    eom_d   = eom_q;
    j_d     = j_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (complete) begin
            fill_d  = '0;
            done_d  = fill_inc;
            eom_d   = in_i.payload.end_of_message;
            j_d     = '0;
            state_d = S_RD;
          end else begin
            fill_d = fill_inc;
          end
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (lob_q) begin
            state_d = S_IDLE;
          end else begin
            j_d     = j_q + AddrW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= '0;
      eom_q   <= 1'b0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      eom_q   <= eom_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem[fill_q[AddrW-1:0]] <= in_i.payload.data_byte;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem[src[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      space_q <= src_fault | src_pad;
      fault_q <= src_fault;
      lob_q   <= src_last;
      lom_q   <= src_last & eom_q;
    end
  end

  assign out_o.valid                   = (state_q == S_OUT);
  assign out_o.payload.cipher_byte     = space_q ? PadChar : rdata_q;
  assign out_o.payload.last_of_block   = lob_q;
  assign out_o.payload.last_of_message = lom_q;
  assign out_o.payload.key_fault       = fault_q;

  `BTC_ASSERT_NEVER(a_no_input_while_emitting, out_o.valid && in_i.ready, "input open during emission")
  `BTC_ASSERT(a_block_start, (in_acc && complete) |=> (state_q == S_RD && j_q == '0 && fill_q == '0), "closed block did not start emission")
  `BTC_ASSERT(a_fill_range, fill_q < CntW'(MAX_BLOCK), "fill count beyond buffer depth")

endmodule
